// ===== rtl/team_grouped_fifo_macros.svh =====
// Assertion macros for the team queue RTL.
// Included by files that carry concurrent checks; expects clk and arst_n in scope.
`ifndef TEAM_GROUPED_FIFO_MACROS_SVH
`define TEAM_GROUPED_FIFO_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while reset is asserted.
`define TGF_ASSERT_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("team queue check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TGF_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("team queue check failed");

`else

`define TGF_ASSERT_IMPLY(label, ante, cons)

`define TGF_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== rtl/tgf_pkg.sv =====
// Package for the team queue: sizes, codes, word and request structs.
// No dependencies; imported by every module of the block but tgf_ram.
package tgf_pkg;

	localparam int ELEMENT_IDS = 65536;
	localparam int TEAMS       = 256;
	localparam int TEAM_DEPTH  = 256;

	localparam int ELEM_W  = $clog2(ELEMENT_IDS);
	localparam int TEAM_W  = $clog2(TEAMS);
	localparam int SLOT_W  = $clog2(TEAM_DEPTH);
	localparam int CNT_W   = $clog2(TEAM_DEPTH + 1);
	localparam int LEN_W   = $clog2(TEAMS + 1);
	localparam int FIFO_AW = TEAM_W + SLOT_W;
	localparam int ALU_W   = (CNT_W > LEN_W) ? CNT_W : LEN_W;
	localparam int VAL_W   = 16;
	localparam int TID_W   = 8;

	typedef enum logic [1:0] {
		KIND_LOAD,
		KIND_ENQ,
		KIND_DEQ,
		KIND_NOP
	} kind_t;

	typedef enum logic [1:0] {
		STAT_OK,
		STAT_EMPTY,
		STAT_FULL
	} status_t;

	typedef struct packed {
		kind_t              kind;
		logic [VAL_W-1:0]   element;
		logic [TID_W-1:0]   team_id;
	} req_t;

	typedef struct packed {
		status_t            status;
		logic [VAL_W-1:0]   value;
	} rsp_t;

	typedef struct packed {
		logic [SLOT_W-1:0]  head;
		logic [CNT_W-1:0]   count;
	} team_state_t;

	typedef enum logic [1:0] {
		ALU_ADD,
		ALU_INC,
		ALU_DEC
	} alu_op_t;

	typedef struct packed {
		alu_op_t            op;
		logic [ALU_W-1:0]   a;
		logic [ALU_W-1:0]   b;
	} alu_req_t;

	typedef struct packed {
		logic               we;
		logic [ELEM_W-1:0]  addr;
		logic [TEAM_W-1:0]  wdata;
	} memb_req_t;

	typedef struct packed {
		logic               we;
		logic [TEAM_W-1:0]  addr;
		team_state_t        wdata;
	} team_req_t;

	typedef struct packed {
		logic               we;
		logic [FIFO_AW-1:0] addr;
		logic [VAL_W-1:0]   wdata;
	} fifo_req_t;

	typedef struct packed {
		logic               we;
		logic [TEAM_W-1:0]  addr;
		logic [TEAM_W-1:0]  wdata;
	} ord_req_t;

	typedef struct packed {
		logic               clearing;
		logic [LEN_W-1:0]   order_len;
	} seq_stat_t;

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOAD,
		ST_MEMB,
		ST_TEAM,
		ST_ENQ_SLOT,
		ST_ENQ_CNT,
		ST_ENQ_ORD,
		ST_LEN_INC,
		ST_ORD_RD,
		ST_DQ_TEAM,
		ST_DQ_FIFO,
		ST_DQ_HEAD,
		ST_DQ_CNT,
		ST_DQ_FRONT,
		ST_DQ_LEN,
		ST_DONE
	} state_t;

endpackage

// ===== rtl/tgf_ram.sv =====
// Generic single-port RAM with registered read data.
// No package dependency; sized by WIDTH and DEPTH.
module tgf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/tgf_alu.sv =====
// Shared adder unit used by the sequencer for every pointer and count update but the sweep address.
// Depends on tgf_pkg.
module tgf_alu (
	input  tgf_pkg::alu_req_t             req,
	output logic [tgf_pkg::ALU_W-1:0]     sum
);

	import tgf_pkg::*;

	always_comb begin
		case (req.op)
			ALU_ADD: sum = req.a + req.b;
			ALU_INC: sum = req.a + ALU_W'(1);
			ALU_DEC: sum = req.a - ALU_W'(1);
			default: sum = req.a;
		endcase
	end

endmodule

// ===== rtl/tgf_seq.sv =====
// Sequencer of the team queue: clearing sweep, per-item step sequence, result register.
// Depends on tgf_pkg; drives the memories and the shared adder from the top level.
module tgf_seq (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  tgf_pkg::req_t                 req,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output tgf_pkg::rsp_t                 rsp,
	output tgf_pkg::memb_req_t            memb_req,
	input  logic [tgf_pkg::TEAM_W-1:0]    memb_rdata,
	output tgf_pkg::team_req_t            team_req,
	input  tgf_pkg::team_state_t          team_rdata,
	output tgf_pkg::fifo_req_t            fifo_req,
	input  logic [tgf_pkg::VAL_W-1:0]     fifo_rdata,
	output tgf_pkg::ord_req_t             ord_req,
	input  logic [tgf_pkg::TEAM_W-1:0]    ord_rdata,
	output tgf_pkg::alu_req_t             alu_req,
	input  logic [tgf_pkg::ALU_W-1:0]     alu_sum,
	output tgf_pkg::seq_stat_t            stat
);

	import tgf_pkg::*;

	localparam logic [ELEM_W-1:0] CLR_LAST = ELEM_W'(ELEMENT_IDS - 1);

	state_t              state_q, state_d;
	logic [ELEM_W-1:0]   clr_q;
	logic [TEAM_W-1:0]   front_q;
	logic [LEN_W-1:0]    len_q;
	logic                rsp_valid_q;
	rsp_t                rsp_q;
	req_t                item_q;
	logic [TEAM_W-1:0]   t_q;
	team_state_t         ts_q;
	logic [VAL_W-1:0]    value_q;
	status_t             status_q;
	logic                rsp_load;
	logic                team_full;
	logic [CNT_W-1:0]    cnt_new;

	assign team_full = team_rdata.count >= CNT_W'(TEAM_DEPTH);
	assign cnt_new   = alu_sum[CNT_W-1:0];

	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		rsp_load  = 1'b0;
		memb_req  = '0;
		team_req  = '0;
		fifo_req  = '0;
		ord_req   = '0;
		alu_req   = '{op: ALU_ADD, a: '0, b: '0};
		case (state_q)
			ST_CLEAR: begin
				memb_req.we   = 1'b1;
				memb_req.addr = clr_q;
				if ({1'b0, clr_q} < (ELEM_W + 1)'(TEAMS)) begin
					team_req.we   = 1'b1;
					team_req.addr = clr_q[TEAM_W-1:0];
				end
				if (clr_q == CLR_LAST) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					case (req.kind)
						KIND_LOAD: state_d = ST_LOAD;
						KIND_ENQ:  state_d = ST_MEMB;
						KIND_DEQ:  state_d = (len_q == '0) ? ST_DONE : ST_ORD_RD;
						default:   state_d = ST_DONE;
					endcase
				end
			end
			ST_LOAD: begin
				memb_req.we    = 1'b1;
				memb_req.addr  = item_q.element[ELEM_W-1:0];
				memb_req.wdata = item_q.team_id[TEAM_W-1:0];
				state_d        = ST_DONE;
			end
			ST_MEMB: begin
				memb_req.addr = item_q.element[ELEM_W-1:0];
				state_d       = ST_TEAM;
			end
			ST_TEAM: begin
				team_req.addr = memb_rdata;
				state_d       = ST_ENQ_SLOT;
			end
			ST_ENQ_SLOT: begin
				alu_req.a = ALU_W'(team_rdata.head);
				alu_req.b = ALU_W'(team_rdata.count);
				if (team_full) begin
					state_d = ST_DONE;
				end else begin
					fifo_req.we    = 1'b1;
					fifo_req.addr  = {t_q, alu_sum[SLOT_W-1:0]};
					fifo_req.wdata = item_q.element;
					state_d        = ST_ENQ_CNT;
				end
			end
			ST_ENQ_CNT: begin
				alu_req.op     = ALU_INC;
				alu_req.a      = ALU_W'(ts_q.count);
				team_req.we    = 1'b1;
				team_req.addr  = t_q;
				team_req.wdata = '{head: ts_q.head, count: cnt_new};
				if (ts_q.count == '0 && len_q < LEN_W'(TEAMS)) begin
					state_d = ST_ENQ_ORD;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_ENQ_ORD: begin
				alu_req.a     = ALU_W'(front_q);
				alu_req.b     = ALU_W'(len_q);
				ord_req.we    = 1'b1;
				ord_req.addr  = alu_sum[TEAM_W-1:0];
				ord_req.wdata = t_q;
				state_d       = ST_LEN_INC;
			end
			ST_LEN_INC: begin
				alu_req.op = ALU_INC;
				alu_req.a  = ALU_W'(len_q);
				state_d    = ST_DONE;
			end
			ST_ORD_RD: begin
				ord_req.addr = front_q;
				state_d      = ST_DQ_TEAM;
			end
			ST_DQ_TEAM: begin
				team_req.addr = ord_rdata;
				state_d       = ST_DQ_FIFO;
			end
			ST_DQ_FIFO: begin
				fifo_req.addr = {t_q, team_rdata.head};
				state_d       = ST_DQ_HEAD;
			end
			ST_DQ_HEAD: begin
				alu_req.op = ALU_INC;
				alu_req.a  = ALU_W'(ts_q.head);
				state_d    = ST_DQ_CNT;
			end
			ST_DQ_CNT: begin
				// hold a zero count at zero
				if (ts_q.count != '0) begin
					alu_req.op = ALU_DEC;
					alu_req.a  = ALU_W'(ts_q.count);
				end
				team_req.we    = 1'b1;
				team_req.addr  = t_q;
				team_req.wdata = '{head: ts_q.head, count: cnt_new};
				state_d        = (cnt_new == '0) ? ST_DQ_FRONT : ST_DONE;
			end
			ST_DQ_FRONT: begin
				alu_req.op = ALU_INC;
				alu_req.a  = ALU_W'(front_q);
				state_d    = ST_DQ_LEN;
			end
			ST_DQ_LEN: begin
				alu_req.op = ALU_DEC;
				alu_req.a  = ALU_W'(len_q);
				state_d    = ST_DONE;
			end
			ST_DONE: begin
				if (!rsp_valid_q || rsp_ready) begin
					rsp_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			front_q     <= '0;
			len_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + ELEM_W'(1);
			end
			if (state_q == ST_LEN_INC || state_q == ST_DQ_LEN) begin
				len_q <= alu_sum[LEN_W-1:0];
			end
			if (state_q == ST_DQ_FRONT) begin
				front_q <= alu_sum[TEAM_W-1:0];
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					item_q   <= req;
					value_q  <= '0;
					status_q <= (req.kind == KIND_DEQ && len_q == '0) ? STAT_EMPTY : STAT_OK;
				end
			end
			ST_TEAM: t_q <= memb_rdata;
			ST_ENQ_SLOT: begin
				ts_q <= team_rdata;
				if (team_full) begin
					status_q <= STAT_FULL;
				end
			end
			ST_DQ_TEAM: t_q  <= ord_rdata;
			ST_DQ_FIFO: ts_q <= team_rdata;
			ST_DQ_HEAD: begin
				value_q   <= fifo_rdata;
				ts_q.head <= alu_sum[SLOT_W-1:0];
			end
			default: ;
		endcase
		if (rsp_load) begin
			rsp_q <= '{status: status_q, value: value_q};
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign stat      = '{clearing: (state_q == ST_CLEAR), order_len: len_q};

endmodule

// ===== rtl/team_grouped_fifo.sv =====
// Top level of the team queue: sequencer, shared adder and the four memories.
// Depends on tgf_pkg, tgf_ram, tgf_alu, tgf_seq and team_grouped_fifo_macros.svh.
//
// Team queue. A load word (kind 0) assigns an element to a team, an enqueue word
// (kind 1) puts the element behind the last waiting member of its team, or opens
// that team at the tail of the team order, and a dequeue word (kind 2) returns the
// head of the front team, retiring the team once it runs empty. Every request
// word yields exactly one response word: status 0 for ok, 1 for a dequeue on an
// empty queue, 2 when the element's team already holds TEAM_DEPTH elements (the
// element is dropped); value carries the dequeued element and is zero otherwise.
// Kind 3 answers ok with value zero and changes nothing. Requests are handled one
// at a time by a step sequencer around one shared adder and single-port memories
// with registered reads: the response register loads once the steps of a
// request are through, which for an enqueue or a dequeue means the chain of
// dependent memory reads (membership, team state, team FIFO / team order) and
// the adder updates that follow, and not while an earlier response still
// waits unaccepted in the output register. req_ready rises again the cycle
// after the response register loads, so the next request is taken while the
// last response waits. After reset the block sweeps the membership store
// back to team 0, one entry per cycle, clearing the per-team head and count
// at the addresses below TEAMS; the sweep covers all ELEMENT_IDS entries
// (65536 at the default size), and req_ready stays low until it ends.
`include "team_grouped_fifo_macros.svh"

module team_grouped_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  tgf_pkg::req_t   req,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output tgf_pkg::rsp_t   rsp
);

	import tgf_pkg::*;

	memb_req_t          memb_req;
	logic [TEAM_W-1:0]  memb_rdata;
	team_req_t          team_req;
	team_state_t        team_rdata;
	fifo_req_t          fifo_req;
	logic [VAL_W-1:0]   fifo_rdata;
	ord_req_t           ord_req;
	logic [TEAM_W-1:0]  ord_rdata;
	alu_req_t           alu_req;
	logic [ALU_W-1:0]   alu_sum;
	seq_stat_t          stat;

	// Step sequencer: owns all control state, the order pointers and the response.
	tgf_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.rsp        (rsp),
		.memb_req   (memb_req),
		.memb_rdata (memb_rdata),
		.team_req   (team_req),
		.team_rdata (team_rdata),
		.fifo_req   (fifo_req),
		.fifo_rdata (fifo_rdata),
		.ord_req    (ord_req),
		.ord_rdata  (ord_rdata),
		.alu_req    (alu_req),
		.alu_sum    (alu_sum),
		.stat       (stat)
	);

	// One adder serves slot, count, head and order pointer arithmetic in turn.
	tgf_alu u_alu (
		.req (alu_req),
		.sum (alu_sum)
	);

	// Team of each element; swept to team 0 after reset.
	tgf_ram #(
		.WIDTH (TEAM_W),
		.DEPTH (ELEMENT_IDS)
	) u_memb_ram (
		.clk   (clk),
		.we    (memb_req.we),
		.addr  (memb_req.addr),
		.wdata (memb_req.wdata),
		.rdata (memb_rdata)
	);

	// Per-team read slot and waiting count; a team is in the order iff its count is nonzero.
	tgf_ram #(
		.WIDTH ($bits(team_state_t)),
		.DEPTH (TEAMS)
	) u_team_ram (
		.clk   (clk),
		.we    (team_req.we),
		.addr  (team_req.addr),
		.wdata (team_req.wdata),
		.rdata (team_rdata)
	);

	// Element storage, one circular region of TEAM_DEPTH slots per team.
	tgf_ram #(
		.WIDTH (VAL_W),
		.DEPTH (TEAMS * TEAM_DEPTH)
	) u_fifo_ram (
		.clk   (clk),
		.we    (fifo_req.we),
		.addr  (fifo_req.addr),
		.wdata (fifo_req.wdata),
		.rdata (fifo_rdata)
	);

	// Circular team order; only entries between front and front + length are read.
	tgf_ram #(
		.WIDTH (TEAM_W),
		.DEPTH (TEAMS)
	) u_ord_ram (
		.clk   (clk),
		.we    (ord_req.we),
		.addr  (ord_req.addr),
		.wdata (ord_req.wdata),
		.rdata (ord_rdata)
	);

	// No request is accepted while the membership sweep runs.
	`TGF_ASSERT_IMPLY(a_no_accept_in_clear, stat.clearing, !req_ready)

	// Take one request at a time: busy right after an acceptance.
	`TGF_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready)

	// The team order never holds more teams than exist.
	`TGF_ASSERT_IMPLY(a_order_len_bound, 1'b1, stat.order_len <= LEN_W'(TEAMS))

	// Any response other than ok carries a zero value.
	`TGF_ASSERT_IMPLY(a_err_value_zero, rsp_valid && rsp.status != STAT_OK, rsp.value == '0)

endmodule
